@@ src/assert_macros.svh @@
// Assertion helpers, sampled on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Cause implies consequence on the next edge.
`define ASSERT_NEXT(lbl, cause, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (cons)) else $error(msg);

`endif

@@ src/kabf_pkg.sv @@
package kabf_pkg;

  localparam int unsigned FieldW = 26;
  localparam int unsigned CovW   = 32;
  localparam int unsigned MulAW  = 34;
  localparam int unsigned MulBW  = 33;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned RndW   = ProdW - 24;
  localparam int unsigned AccW   = RndW + 1;
  localparam int unsigned NumW   = 56;

  localparam logic [7:0] REG_ANGLE_NOISE   = 8'd0;
  localparam logic [7:0] REG_BIAS_NOISE    = 8'd1;
  localparam logic [7:0] REG_MEASURE_NOISE = 8'd2;
  localparam logic [7:0] REG_TIME_STEP     = 8'd3;

  localparam logic signed [AccW-1:0] AngleMax = AccW'(16777216);
  localparam logic signed [AccW-1:0] CovMax   = AccW'(64'sd2147483647);
  localparam logic signed [AccW-1:0] CovMin   = -AccW'(64'sd2147483648);

  typedef enum logic [16:0] {
    ST_IDLE = 17'h00001,
    ST_PA   = 17'h00002,
    ST_PB   = 17'h00004,
    ST_PC   = 17'h00008,
    ST_PD   = 17'h00010,
    ST_PE   = 17'h00020,
    ST_PF   = 17'h00040,
    ST_DV0  = 17'h00080,
    ST_DV1  = 17'h00100,
    ST_CA   = 17'h00200,
    ST_CB   = 17'h00400,
    ST_CC   = 17'h00800,
    ST_CD   = 17'h01000,
    ST_CE   = 17'h02000,
    ST_CF   = 17'h04000,
    ST_CG   = 17'h08000,
    ST_DONE = 17'h10000
  } state_t;

  function automatic logic signed [CovW-1:0] sat32(input logic signed [AccW-1:0] v);
    if (v > CovMax) return CovMax[CovW-1:0];
    if (v < CovMin) return CovMin[CovW-1:0];
    return v[CovW-1:0];
  endfunction

  function automatic logic signed [FieldW-1:0] sat_ang(input logic signed [AccW-1:0] v);
    if (v > AngleMax) return AngleMax[FieldW-1:0];
    if (v < -AngleMax) return -AngleMax[FieldW-1:0];
    return v[FieldW-1:0];
  endfunction

  // Apply sign and clamp a quotient magnitude to the signed 32-bit range.
  function automatic logic signed [CovW-1:0] div_fin(input logic [NumW-1:0] q,
                                                    input logic neg);
    logic [NumW-1:0] lim;
    lim = NumW'(64'd2147483647);
    if (neg) begin
      if (q > lim) return CovMin[CovW-1:0];
      return -q[CovW-1:0];
    end
    if (q > lim) return CovMax[CovW-1:0];
    return q[CovW-1:0];
  endfunction

endpackage

@@ src/kalman_angle_bias_filter.sv @@
// Each input word runs one update: 10 multiply steps on one shared 34x33
// multiplier and two restoring divides; both divides are skipped when
// P00 + R is not positive. Input is refused while an update runs or a
// result waits for the output register. Synchronous active-low reset
// clears estimates and covariance.
`include "assert_macros.svh"

module kalman_angle_bias_filter
  import kabf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // [25:0] measured_angle, [51:26] gyro_rate
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [25:0] angle_estimate, [51:26] bias_estimate
  input  logic        cfg_we,
  input  logic [7:0]  cfg_addr,
  input  logic [28:0] cfg_wdata
);

  state_t state_r;

  logic [24:0] an_r, bn_r;
  logic [28:0] mn_r;
  logic [20:0] dt_r;

  logic signed [FieldW-1:0] angle_r, bias_r, meas_r, rate_r;
  logic signed [CovW-1:0]   c00_r, c01_r, c10_r, c11_r, k0_r, k1_r, t1_r;
  logic signed [26:0]       y_r;
  logic signed [ProdW-1:0]  prod_r;
  logic [31:0]              d_r;
  logic [NumW-1:0]          num_r, q_r;
  logic [32:0]              rem_r;
  logic [5:0]               cnt_r;
  logic                     neg_r;
  logic                     out_valid_r;
  logic [51:0]              out_data_r;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] rsum;
  logic signed [AccW-1:0]  rnd;
  logic signed [MulAW-1:0] inner;
  logic signed [26:0]      y_now;
  logic signed [32:0]      s_sum;
  logic [32:0]             rem_sh;
  logic [33:0]             diff;
  logic                    qbit;
  logic [NumW-1:0]         q_nxt;
  logic [31:0]             c00_mag, c10_mag;

  logic in_acc;
  logic in_div;
  assign in_acc    = in_tvalid && in_tready;
  assign in_div    = (state_r == ST_DV0) || (state_r == ST_DV1);
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_data_r};

  assign rsum  = prod_r + (ProdW'(1) <<< 23);
  assign rnd   = AccW'($signed(rsum[ProdW-1:24]));
  assign inner = MulAW'(t1_r) - MulAW'(c01_r) - MulAW'(c10_r) + MulAW'($signed({1'b0, an_r}));
  assign y_now = 27'(meas_r) - 27'(angle_r);
  assign s_sum = 33'(c00_r) + $signed({4'b0, mn_r});

  assign c00_mag = c00_r[31] ? 32'(-c00_r) : 32'(c00_r);
  assign c10_mag = c10_r[31] ? 32'(-c10_r) : 32'(c10_r);

  assign rem_sh = {rem_r[31:0], num_r[NumW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, d_r};
  assign qbit   = !diff[33];
  assign q_nxt  = {q_r[NumW-2:0], qbit};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_PA: begin
        mul_a = MulAW'(27'(rate_r) - 27'(bias_r));
        mul_b = $signed({12'b0, dt_r});
      end
      ST_PB: begin
        mul_a = MulAW'(c11_r);
        mul_b = $signed({12'b0, dt_r});
      end
      ST_PD: begin
        mul_a = inner;
        mul_b = $signed({12'b0, dt_r});
      end
      ST_PE: begin
        mul_a = MulAW'($signed({1'b0, bn_r}));
        mul_b = $signed({12'b0, dt_r});
      end
      ST_CA: begin
        mul_a = MulAW'(y_now);
        mul_b = MulBW'(k0_r);
      end
      ST_CB: begin
        mul_a = MulAW'(y_r);
        mul_b = MulBW'(k1_r);
      end
      ST_CC: begin
        mul_a = MulAW'(c00_r);
        mul_b = MulBW'(k1_r);
      end
      ST_CD: begin
        mul_a = MulAW'(c01_r);
        mul_b = MulBW'(k1_r);
      end
      ST_CE: begin
        mul_a = MulAW'(c00_r);
        mul_b = MulBW'(k0_r);
      end
      ST_CF: begin
        mul_a = MulAW'(c01_r);
        mul_b = MulBW'(k0_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      an_r        <= 25'd16777;
      bn_r        <= 25'd50332;
      mn_r        <= 29'd16777216;
      dt_r        <= 21'd33554;
      angle_r     <= '0;
      bias_r      <= '0;
      c00_r       <= '0;
      c01_r       <= '0;
      c10_r       <= '0;
      c11_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_ANGLE_NOISE:   an_r <= cfg_wdata[24:0];
          REG_BIAS_NOISE:    bn_r <= cfg_wdata[24:0];
          REG_MEASURE_NOISE: mn_r <= cfg_wdata;
          REG_TIME_STEP:     dt_r <= cfg_wdata[20:0];
          default: ;
        endcase
      end
      if ((state_r == ST_DONE) && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            meas_r  <= in_tdata[25:0];
            rate_r  <= in_tdata[51:26];
            state_r <= ST_PA;
          end
        end
        ST_PA: state_r <= ST_PB;
        ST_PB: begin
          angle_r <= sat_ang(AccW'(angle_r) + rnd);
          state_r <= ST_PC;
        end
        ST_PC: begin
          t1_r    <= rnd[CovW-1:0];
          state_r <= ST_PD;
        end
        ST_PD: begin
          c01_r   <= sat32(AccW'(c01_r) - AccW'(t1_r));
          c10_r   <= sat32(AccW'(c10_r) - AccW'(t1_r));
          state_r <= ST_PE;
        end
        ST_PE: begin
          c00_r   <= sat32(AccW'(c00_r) + rnd);
          state_r <= ST_PF;
        end
        ST_PF: begin
          c11_r <= sat32(AccW'(c11_r) + rnd);
          if (s_sum > 0) begin
            d_r     <= s_sum[31:0];
            num_r   <= {c00_mag, 24'b0};
            neg_r   <= c00_r[31];
            rem_r   <= '0;
            q_r     <= '0;
            cnt_r   <= '0;
            state_r <= ST_DV0;
          end else begin
            k0_r    <= '0;
            k1_r    <= '0;
            state_r <= ST_CA;
          end
        end
        ST_DV0, ST_DV1: begin
          if (cnt_r == 6'(NumW - 1)) begin
            cnt_r <= '0;
            rem_r <= '0;
            q_r   <= '0;
            if (state_r == ST_DV0) begin
              k0_r    <= div_fin(q_nxt, neg_r);
              num_r   <= {c10_mag, 24'b0};
              neg_r   <= c10_r[31];
              state_r <= ST_DV1;
            end else begin
              k1_r    <= div_fin(q_nxt, neg_r);
              num_r   <= num_r << 1;
              state_r <= ST_CA;
            end
          end else begin
            rem_r <= qbit ? diff[32:0] : rem_sh;
            num_r <= num_r << 1;
            q_r   <= q_nxt;
            cnt_r <= cnt_r + 6'd1;
          end
        end
        ST_CA: begin
          y_r     <= y_now;
          state_r <= ST_CB;
        end
        ST_CB: begin
          angle_r <= sat_ang(AccW'(angle_r) + rnd);
          state_r <= ST_CC;
        end
        ST_CC: begin
          bias_r  <= sat_ang(AccW'(bias_r) + rnd);
          state_r <= ST_CD;
        end
        ST_CD: begin
          c10_r   <= sat32(AccW'(c10_r) - rnd);
          state_r <= ST_CE;
        end
        ST_CE: begin
          c11_r   <= sat32(AccW'(c11_r) - rnd);
          state_r <= ST_CF;
        end
        ST_CF: begin
          c00_r   <= sat32(AccW'(c00_r) - rnd);
          state_r <= ST_CG;
        end
        ST_CG: begin
          c01_r   <= sat32(AccW'(c01_r) - rnd);
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {bias_r, angle_r};
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_start, in_acc, state_r == ST_PA, "accepted word did not start update")
  `ASSERT_ALWAYS(a_cnt, !in_div || (cnt_r < 6'(NumW)), "divider count overrun")
  `ASSERT_ALWAYS(a_ang, (angle_r <= 26'sd16777216) && (angle_r >= -26'sd16777216), "angle range")
  `ASSERT_NEXT(a_out, (state_r == ST_DONE) && !out_valid_r, out_valid_r, "result not loaded")

endmodule
